@@ hdl/gzc_pkg.sv @@
package gzc_pkg;

    // window geometry
    localparam int DEPTH    = 64;
    localparam int MIN_FILL = 10;
    localparam int PTR_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int START_W  = CNT_W + 1;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int PEAK_W   = 16;
    localparam int AMP_W    = 15;
    localparam int FREQ_W   = 16;

    // frequency scale: 100 samples per second, two crossings per period, mHz
    localparam int FREQ_SCALE = 50000;
    localparam int SCALE_W    = 16;
    localparam int NUM_W      = CNT_W + SCALE_W;
    localparam int DIV_CNT_W  = $clog2(NUM_W + 1);

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_MIN_AMP  = 2'd0;
    localparam t_reg_idx REG_MIN_FREQ = 2'd1;
    localparam t_reg_idx REG_MAX_FREQ = 2'd2;

    // register reset values
    localparam logic [AMP_W-1:0]  RST_MIN_AMP  = AMP_W'(800);
    localparam logic [FREQ_W-1:0] RST_MIN_FREQ = FREQ_W'(2000);
    localparam logic [FREQ_W-1:0] RST_MAX_FREQ = FREQ_W'(15000);

    // configuration bundle handed to the datapath
    typedef struct packed {
        logic [AMP_W-1:0]  min_amplitude;
        logic [FREQ_W-1:0] min_freq_mhz;
        logic [FREQ_W-1:0] max_freq_mhz;
    } t_cfg;

endpackage

@@ hdl/gzc_if.sv @@
// input item channel
interface gzc_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [gzc_pkg::SAMPLE_W-1:0]   gyro_z_sample;

    modport source (output valid, output gyro_z_sample, input ready);
    modport sink   (input valid, input gyro_z_sample, output ready);
endinterface

// result item channel
interface gzc_out_if;
    logic                                  valid;
    logic                                  ready;
    logic [gzc_pkg::FREQ_W-1:0]            wag_freq_mhz;

    modport source (output valid, output wag_freq_mhz, input ready);
    modport sink   (input valid, input wag_freq_mhz, output ready);
endinterface

@@ hdl/gzc_ram.sv @@
module gzc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/gzc_div.sv @@
module gzc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [gzc_pkg::NUM_W-1:0]   i_num,
    input  logic [gzc_pkg::CNT_W-1:0]   i_den,
    output logic                        o_done,
    output logic [gzc_pkg::NUM_W-1:0]   o_quot
);

    logic                            r_busy, n_busy;
    logic                            r_done, n_done;
    logic [gzc_pkg::DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic [gzc_pkg::CNT_W-1:0]       r_rem, n_rem;
    logic [gzc_pkg::NUM_W-1:0]       r_quo, n_quo;
    logic [gzc_pkg::CNT_W:0]         trial;
    logic                            fits;

    // one restoring step per cycle, dividend shifts out as quotient shifts in
    always_comb begin
        trial  = {r_rem, r_quo[gzc_pkg::NUM_W-1]};
        fits   = (trial >= {1'b0, i_den});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_num;
        end else if (r_busy) begin
            n_rem = fits ? gzc_pkg::CNT_W'(trial - {1'b0, i_den})
                         : trial[gzc_pkg::CNT_W-1:0];
            n_quo = {r_quo[gzc_pkg::NUM_W-2:0], fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == gzc_pkg::DIV_CNT_W'(gzc_pkg::NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

@@ hdl/gzc_cfg.sv @@
module gzc_cfg (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [gzc_pkg::APB_ADDR_W-1:0]    i_paddr,
    input  logic [gzc_pkg::APB_DATA_W-1:0]    i_pwdata,
    output logic [gzc_pkg::APB_DATA_W-1:0]    o_prdata,
    output logic                              o_pready,
    output gzc_pkg::t_cfg                     o_cfg
);

    gzc_pkg::t_cfg     r_cfg;
    gzc_pkg::t_reg_idx reg_idx;
    logic              wr_en;

    assign reg_idx  = i_paddr[3:2];
    assign wr_en    = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;

    // register writes, unknown index ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_amplitude <= gzc_pkg::RST_MIN_AMP;
            r_cfg.min_freq_mhz  <= gzc_pkg::RST_MIN_FREQ;
            r_cfg.max_freq_mhz  <= gzc_pkg::RST_MAX_FREQ;
        end else if (wr_en) begin
            unique case (reg_idx)
                gzc_pkg::REG_MIN_AMP: begin
                    r_cfg.min_amplitude <= i_pwdata[gzc_pkg::AMP_W-1:0];
                end
                gzc_pkg::REG_MIN_FREQ: begin
                    r_cfg.min_freq_mhz <= i_pwdata[gzc_pkg::FREQ_W-1:0];
                end
                gzc_pkg::REG_MAX_FREQ: begin
                    r_cfg.max_freq_mhz <= i_pwdata[gzc_pkg::FREQ_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            gzc_pkg::REG_MIN_AMP:  o_prdata = gzc_pkg::APB_DATA_W'(r_cfg.min_amplitude);
            gzc_pkg::REG_MIN_FREQ: o_prdata = gzc_pkg::APB_DATA_W'(r_cfg.min_freq_mhz);
            gzc_pkg::REG_MAX_FREQ: o_prdata = gzc_pkg::APB_DATA_W'(r_cfg.max_freq_mhz);
            default:               o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

@@ hdl/gyro_zero_crossing_wag_detector.sv @@
// channel   | dir | handshake      | payload
// i_sample  | in  | valid / ready  | gyro_z_sample, signed 16 bit
// o_freq    | out | valid / ready  | wag_freq_mhz, unsigned 16 bit
// apb       | in  | psel / penable | three config registers at 0x0, 0x4, 0x8
//
// while the window holds fewer than MIN_FILL samples an item gives a zero
// result without a walk or divide; otherwise it takes one ram read per held
// sample, then a 23-step serial divide by the fill count
// the ring buffer needs no clearing pass: only written entries are ever read
// reset is synchronous, active low; a finished result waits in an output
// register and a new item is taken meanwhile; only the next result stalls
module gyro_zero_crossing_wag_detector (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    gzc_in_if.sink                            i_sample,
    gzc_out_if.source                         o_freq,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [gzc_pkg::APB_ADDR_W-1:0]    i_paddr,
    input  logic [gzc_pkg::APB_DATA_W-1:0]    i_pwdata,
    output logic [gzc_pkg::APB_DATA_W-1:0]    o_prdata,
    output logic                              o_pready
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_WALK = 5'b00010,
        S_MUL  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                          r_state, n_state;
    gzc_pkg::t_cfg                   cfg;

    logic [gzc_pkg::PTR_W-1:0]       r_wp, n_wp;
    logic [gzc_pkg::CNT_W-1:0]       r_fill, n_fill;
    logic [gzc_pkg::PTR_W-1:0]       r_addr, n_addr;
    logic [gzc_pkg::CNT_W-1:0]       r_iss, n_iss;
    logic [gzc_pkg::CNT_W-1:0]       r_proc, n_proc;
    logic                            r_rv;
    logic [gzc_pkg::PEAK_W-1:0]      r_peak, n_peak;
    logic                            r_prev_pos, n_prev_pos;
    logic                            r_prev_neg, n_prev_neg;
    logic [gzc_pkg::CNT_W-1:0]       r_cross, n_cross;
    logic [gzc_pkg::NUM_W-1:0]       r_num, n_num;
    logic                            r_div_start, n_div_start;
    logic [gzc_pkg::FREQ_W-1:0]      r_res, n_res;
    logic                            r_ov, n_ov;
    logic [gzc_pkg::FREQ_W-1:0]      r_out, n_out;

    logic                            accept;
    logic                            issue;
    logic [gzc_pkg::START_W-1:0]     start_sum;
    logic [gzc_pkg::PTR_W-1:0]       start;
    logic [gzc_pkg::SAMPLE_W-1:0]    rdata;
    logic [gzc_pkg::SAMPLE_W:0]      mag;
    logic                            smp_pos, smp_neg;
    logic                            div_done;
    logic [gzc_pkg::NUM_W-1:0]       quot;
    logic                            qualifies;

    // configuration registers
    gzc_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_pready  (o_pready),
        .o_cfg     (cfg)
    );

    // sample ring buffer
    gzc_ram #(
        .DEPTH (gzc_pkg::DEPTH),
        .WIDTH (gzc_pkg::SAMPLE_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_wp),
        .i_wdata (i_sample.gyro_z_sample),
        .i_re    (issue),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    // crossings * scale / fill
    gzc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_start),
        .i_num   (r_num),
        .i_den   (r_fill),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    assign i_sample.ready = (r_state == S_IDLE);
    assign accept         = i_sample.valid && i_sample.ready;
    assign issue          = (r_state == S_WALK) && (r_iss < r_fill);

    // pointer and fill after this item, oldest entry of the window
    always_comb begin
        n_wp   = (r_wp == gzc_pkg::PTR_W'(gzc_pkg::DEPTH - 1)) ? '0 : r_wp + 1'b1;
        n_fill = (r_fill < gzc_pkg::CNT_W'(gzc_pkg::DEPTH)) ? r_fill + 1'b1 : r_fill;
        start_sum = gzc_pkg::START_W'(n_wp) + gzc_pkg::START_W'(gzc_pkg::DEPTH)
                  - gzc_pkg::START_W'(n_fill);
        if (start_sum >= gzc_pkg::START_W'(gzc_pkg::DEPTH)) begin
            start = gzc_pkg::PTR_W'(start_sum - gzc_pkg::START_W'(gzc_pkg::DEPTH));
        end else begin
            start = gzc_pkg::PTR_W'(start_sum);
        end
    end

    // magnitude and sign of the sample coming back from the ram
    assign mag     = rdata[gzc_pkg::SAMPLE_W-1]
                   ? (gzc_pkg::SAMPLE_W+1)'(-$signed({rdata[gzc_pkg::SAMPLE_W-1], rdata}))
                   : {1'b0, rdata};
    assign smp_neg = rdata[gzc_pkg::SAMPLE_W-1];
    assign smp_pos = !rdata[gzc_pkg::SAMPLE_W-1] && (rdata != '0);

    // final range and amplitude test
    assign qualifies = (r_peak > gzc_pkg::PEAK_W'(cfg.min_amplitude))
                    && (quot >= gzc_pkg::NUM_W'(cfg.min_freq_mhz))
                    && (quot <= gzc_pkg::NUM_W'(cfg.max_freq_mhz));

    // sequencer: write, walk, scale, divide, hand over; short window: zero
    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_iss       = r_iss;
        n_proc      = r_proc;
        n_peak      = r_peak;
        n_prev_pos  = r_prev_pos;
        n_prev_neg  = r_prev_neg;
        n_cross     = r_cross;
        n_num       = r_num;
        n_div_start = 1'b0;
        n_res       = r_res;
        n_ov        = r_ov;
        n_out       = r_out;

        if (o_freq.valid && o_freq.ready) begin
            n_ov = 1'b0;
        end

        if (issue) begin
            n_iss  = r_iss + 1'b1;
            n_addr = (r_addr == gzc_pkg::PTR_W'(gzc_pkg::DEPTH - 1)) ? '0
                                                                    : r_addr + 1'b1;
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_addr     = start;
                    n_iss      = '0;
                    n_proc     = '0;
                    n_peak     = '0;
                    n_prev_pos = 1'b0;
                    n_prev_neg = 1'b0;
                    n_cross    = '0;
                    n_res      = '0;
                    if (32'(n_fill) < gzc_pkg::MIN_FILL) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (r_rv) begin
                    if (gzc_pkg::PEAK_W'(mag) > r_peak) begin
                        n_peak = gzc_pkg::PEAK_W'(mag);
                    end
                    if ((smp_pos && r_prev_neg) || (smp_neg && r_prev_pos)) begin
                        n_cross = r_cross + 1'b1;
                    end
                    n_prev_pos = smp_pos;
                    n_prev_neg = smp_neg;
                    n_proc     = r_proc + 1'b1;
                    if (r_proc == r_fill - 1'b1) begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_num       = gzc_pkg::NUM_W'(r_cross)
                            * gzc_pkg::NUM_W'(gzc_pkg::FREQ_SCALE);
                n_div_start = 1'b1;
                n_state     = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    n_res   = qualifies ? quot[gzc_pkg::FREQ_W-1:0] : '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_ov || o_freq.ready) begin
                    n_out   = r_res;
                    n_ov    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_fill      <= '0;
            r_iss       <= '0;
            r_proc      <= '0;
            r_rv        <= 1'b0;
            r_div_start <= 1'b0;
            r_ov        <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iss       <= n_iss;
            r_proc      <= n_proc;
            r_rv        <= issue;
            r_div_start <= n_div_start;
            r_ov        <= n_ov;
            if (accept) begin
                r_wp   <= n_wp;
                r_fill <= n_fill;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_peak     <= n_peak;
        r_prev_pos <= n_prev_pos;
        r_prev_neg <= n_prev_neg;
        r_cross    <= n_cross;
        r_num      <= n_num;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    assign o_freq.valid        = r_ov;
    assign o_freq.wag_freq_mhz = r_out;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= gzc_pkg::CNT_W'(gzc_pkg::DEPTH))
        else $error("fill count beyond window depth");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_iss <= r_fill) && (r_proc <= r_iss))
        else $error("window walk read past the held samples");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ov) |-> $past(r_state == S_DONE))
        else $error("result shown without finishing an item");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");
`endif

endmodule
